// ===== design/gfla_pkg.sv =====
package gfla_pkg;

  // Fixed widths of the stream fields.
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned OPND_W = 8;
  localparam int unsigned RES_W  = 8;

  // Default field size in bits, GF(2^8).
  localparam int unsigned FIELD_BITS_DEF = 8;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD       = 3'd0,
    OP_MUL       = 3'd1,
    OP_DIV       = 3'd2,
    OP_POW       = 3'd3,
    OP_IDX2POLY  = 3'd4,
    OP_POLY2IDX  = 3'd5
  } gfla_op_e;

  // Control that travels down the pipeline beside the data.
  typedef struct packed {
    gfla_op_e op;
    logic     a_zero;
    logic     b_zero;
  } gfla_ctrl_t;

  // Primitive polynomial for each supported field size.
  function automatic logic [16:0] gfla_prim_poly(input int unsigned fb);
    logic [16:0] poly;
    unique case (fb)
      2:       poly = 17'h00007;
      3:       poly = 17'h0000B;
      4:       poly = 17'h00013;
      5:       poly = 17'h00025;
      6:       poly = 17'h00043;
      7:       poly = 17'h00083;
      8:       poly = 17'h0011D;
      9:       poly = 17'h00211;
      10:      poly = 17'h00409;
      11:      poly = 17'h00805;
      12:      poly = 17'h01053;
      13:      poly = 17'h0201B;
      14:      poly = 17'h04443;
      15:      poly = 17'h08003;
      default: poly = 17'h1100B;
    endcase
    return poly;
  endfunction

  // Polynomial form of alpha^idx, evaluated at elaboration to build the ROMs.
  // The all-ones index stands for the zero element.
  function automatic logic [15:0] gfla_antilog(input int unsigned idx,
                                               input int unsigned fb);
    int unsigned zero_idx;
    int unsigned poly;
    int unsigned v;
    zero_idx = (32'd1 << fb) - 32'd1;
    poly     = 32'(gfla_prim_poly(fb));
    v        = 32'd1;
    if (idx == zero_idx) begin
      v = 32'd0;
    end else begin
      for (int unsigned k = 0; k < idx; k++) begin
        v = v << 1;
        if (v > zero_idx) begin
          v = v ^ poly;
        end
      end
    end
    return 16'(v & zero_idx);
  endfunction

endpackage

// ===== design/gfla_front.sv =====
module gfla_front #(
  parameter int unsigned FIELD_BITS = gfla_pkg::FIELD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  gfla_pkg::gfla_op_e           op_i,
  input  logic [gfla_pkg::OPND_W-1:0]  a_i,
  input  logic [gfla_pkg::OPND_W-1:0]  b_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output gfla_pkg::gfla_ctrl_t         ctrl_o,
  output logic [FIELD_BITS-1:0]        a_o,
  output logic [FIELD_BITS-1:0]        poly_o,
  output logic [FIELD_BITS+7:0]        raw_o
);
  import gfla_pkg::*;

  localparam int unsigned FieldSize = 1 << FIELD_BITS;
  localparam int unsigned RawW      = FIELD_BITS + 8;
  localparam logic [FIELD_BITS-1:0] ZeroIdx = '1;

  logic [FIELD_BITS-1:0] antilog_rom [FieldSize];

  for (genvar i = 0; i < FieldSize; i++) begin : g_antilog
    assign antilog_rom[i] = FIELD_BITS'(gfla_antilog(i, FIELD_BITS));
  end

  logic                  valid_q;
  gfla_ctrl_t            ctrl_d, ctrl_q;
  logic [FIELD_BITS-1:0] a, b;
  logic [FIELD_BITS-1:0] a_q;
  logic [FIELD_BITS-1:0] poly_d, poly_q;
  logic [RawW-1:0]       raw_d, raw_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    a = FIELD_BITS'(a_i);
    b = FIELD_BITS'(b_i);
    ctrl_d.op     = op_i;
    ctrl_d.a_zero = (a == ZeroIdx);
    ctrl_d.b_zero = (b == ZeroIdx);
    if (op_i == OP_ADD) begin
      poly_d = antilog_rom[a] ^ antilog_rom[b];
    end else begin
      poly_d = antilog_rom[a];
    end
    // The exponent arithmetic is reduced modulo 2^m-1 further down.
    unique case (op_i)
      OP_MUL:  raw_d = RawW'(a) + RawW'(b);
      OP_DIV:  raw_d = RawW'(a) + RawW'(ZeroIdx) - RawW'(b);
      OP_POW:  raw_d = RawW'(a) * RawW'(b);
      default: raw_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_d;
      a_q    <= a;
      poly_q <= poly_d;
      raw_q  <= raw_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign a_o     = a_q;
  assign poly_o  = poly_q;
  assign raw_o   = raw_q;

endmodule

// ===== design/gfla_mid.sv =====
module gfla_mid #(
  parameter int unsigned FIELD_BITS = gfla_pkg::FIELD_BITS_DEF,
  parameter int unsigned SUM_W      = FIELD_BITS + 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  gfla_pkg::gfla_ctrl_t  ctrl_i,
  input  logic [FIELD_BITS-1:0] a_i,
  input  logic [FIELD_BITS-1:0] poly_i,
  input  logic [FIELD_BITS+7:0] raw_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output gfla_pkg::gfla_ctrl_t  ctrl_o,
  output logic [FIELD_BITS-1:0] tbl_o,
  output logic [SUM_W-1:0]      sum_o
);
  import gfla_pkg::*;

  localparam int unsigned FieldSize = 1 << FIELD_BITS;
  localparam int unsigned RawW      = FIELD_BITS + 8;
  localparam int unsigned NumChunks = (RawW + FIELD_BITS - 1) / FIELD_BITS;
  localparam int unsigned PadW      = NumChunks * FIELD_BITS;

  logic [FIELD_BITS-1:0] log_rom [FieldSize];

  // The antilog map is a permutation, so each log entry is driven once.
  for (genvar i = 0; i < FieldSize; i++) begin : g_log
    assign log_rom[FIELD_BITS'(gfla_antilog(i, FIELD_BITS))] = FIELD_BITS'(i);
  end

  logic                  valid_q;
  gfla_ctrl_t            ctrl_q;
  logic [FIELD_BITS-1:0] log_idx;
  logic [FIELD_BITS-1:0] tbl_d, tbl_q;
  logic [PadW-1:0]       raw_pad;
  logic [SUM_W-1:0]      sum_d, sum_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    log_idx = (ctrl_i.op == OP_POLY2IDX) ? a_i : poly_i;
    tbl_d   = (ctrl_i.op == OP_IDX2POLY) ? poly_i : log_rom[log_idx];
    // Since 2^m is 1 modulo 2^m-1, adding the m-bit chunks keeps the residue.
    raw_pad = PadW'(raw_i);
    sum_d   = '0;
    for (int unsigned k = 0; k < NumChunks; k++) begin
      sum_d = sum_d + SUM_W'(raw_pad[k*FIELD_BITS +: FIELD_BITS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_i;
      tbl_q  <= tbl_d;
      sum_q  <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign tbl_o   = tbl_q;
  assign sum_o   = sum_q;

endmodule

// ===== design/gfla_back.sv =====
module gfla_back #(
  parameter int unsigned FIELD_BITS = gfla_pkg::FIELD_BITS_DEF,
  parameter int unsigned SUM_W      = FIELD_BITS + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  gfla_pkg::gfla_ctrl_t        ctrl_i,
  input  logic [FIELD_BITS-1:0]       tbl_i,
  input  logic [SUM_W-1:0]            sum_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [gfla_pkg::RES_W-1:0]  result_o
);
  import gfla_pkg::*;

  localparam int unsigned NumFolds = 4;
  localparam logic [FIELD_BITS-1:0] ZeroIdx = '1;

  logic                  valid_q;
  logic [SUM_W-1:0]      fold;
  logic [FIELD_BITS-1:0] mod_val;
  logic [FIELD_BITS-1:0] res;
  logic [RES_W-1:0]      result_d, result_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    fold = sum_i;
    for (int unsigned k = 0; k < NumFolds; k++) begin
      fold = SUM_W'(fold[FIELD_BITS-1:0]) + (fold >> FIELD_BITS);
    end
    // After folding, the all-ones value is the residue zero.
    mod_val = (fold[FIELD_BITS-1:0] == ZeroIdx) ? '0 : fold[FIELD_BITS-1:0];
    unique case (ctrl_i.op)
      OP_ADD:      res = tbl_i;
      OP_MUL:      res = (ctrl_i.a_zero || ctrl_i.b_zero) ? ZeroIdx : mod_val;
      OP_DIV:      res = (ctrl_i.a_zero || ctrl_i.b_zero) ? ZeroIdx : mod_val;
      OP_POW:      res = ctrl_i.a_zero ? ZeroIdx : mod_val;
      OP_IDX2POLY: res = tbl_i;
      OP_POLY2IDX: res = tbl_i;
      default:     res = '0;
    endcase
    result_d = RES_W'(res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== design/gf_log_domain_alu_unit.sv =====
// Arithmetic unit for GF(2^m) with elements in exponent form; the all-ones
// index is the zero element. Each input word carries one request on the
// slave stream: tuser selects add, multiply, divide, power, index to
// polynomial or polynomial to index, and tdata holds the two operands.
// Every request gives exactly one result word on the master stream.
// The unit is a three-stage pipeline: antilog lookup and exponent add,
// subtract or multiply, then log lookup and chunk sum, then the modulo fold
// and the result select into the output register. A request taken into the
// front register moves on through the mid register to the back register,
// which drives the result word on the master stream. One request can be
// taken every cycle while the master stream accepts results.
// Each stage keeps its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver holds the output word while
// empty stages upstream keep filling; input is refused only when all three
// stages are full. The log and antilog tables are constant ROMs, so reset
// only clears the valid bits and the unit is ready as soon as reset is
// released.
module gf_log_domain_alu_unit #(
  parameter int unsigned FIELD_BITS = gfla_pkg::FIELD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // operand_a, operand_b
  input  logic [gfla_pkg::REQ_W-1:0] s_axis_tuser,  // req_type
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [gfla_pkg::RES_W-1:0] m_axis_tdata   // result_value
);
  import gfla_pkg::*;

  localparam int unsigned SumW = FIELD_BITS + 4;

  logic                  f_valid, f_ready;
  gfla_ctrl_t            f_ctrl;
  logic [FIELD_BITS-1:0] f_a, f_poly;
  logic [FIELD_BITS+7:0] f_raw;
  logic                  m_valid, m_ready;
  gfla_ctrl_t            m_ctrl;
  logic [FIELD_BITS-1:0] m_tbl;
  logic [SumW-1:0]       m_sum;

  gfla_front #(
    .FIELD_BITS(FIELD_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .op_i    (gfla_op_e'(s_axis_tuser)),
    .a_i     (s_axis_tdata[7:0]),
    .b_i     (s_axis_tdata[15:8]),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .ctrl_o  (f_ctrl),
    .a_o     (f_a),
    .poly_o  (f_poly),
    .raw_o   (f_raw)
  );

  gfla_mid #(
    .FIELD_BITS(FIELD_BITS),
    .SUM_W     (SumW)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .ctrl_i  (f_ctrl),
    .a_i     (f_a),
    .poly_i  (f_poly),
    .raw_i   (f_raw),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .ctrl_o  (m_ctrl),
    .tbl_o   (m_tbl),
    .sum_o   (m_sum)
  );

  gfla_back #(
    .FIELD_BITS(FIELD_BITS),
    .SUM_W     (SumW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (m_valid),
    .ready_o  (m_ready),
    .ctrl_i   (m_ctrl),
    .tbl_i    (m_tbl),
    .sum_i    (m_sum),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (m_axis_tdata)
  );

endmodule
